@@ rtl/core/strmax_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and fixed widths for the segment tree range maximum unit.
package strmax_pkg;

    localparam int COUNT_BITS = 11;
    localparam int INDEX_BITS = 10;
    localparam int DATA_BITS  = 32;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_LEAF,
        S_UPD_RD,
        S_UPD_WR,
        S_Q_RD,
        S_Q_ACC
    } t_state;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic leaf_wr;
        logic upd_wr;
        logic rd_query;
        logic q_acc;
        logic finish;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic load_ok;
        logic q_empty;
        logic upd_last;
        logic q_last;
    } t_dp_status;

endpackage

@@ rtl/core/segment_tree_range_max_unit.sv @@
`timescale 1ns / 1ps
// Top level of the segment tree range maximum unit.
//
//  Channel   Signals                                          Handshake
//  command   i_op, i_element_index, i_element_value,          i_start high, o_busy low
//            i_range_low, i_range_high
//  result    o_max_value                                      o_valid strobe, one cycle
//  config    i_cfg_wdata                                      i_cfg_we high
//
// A load beat keeps o_busy high after accept for a leaf write, then a read and a write of
// the node memory for each level above the leaf.
// A query beat walks the tree level by level, with a read and an accumulate step for each
// level; its result strobes in the cycle after the last step, an empty range in the cycle
// after accept.
// After reset the node memory is cleared one node a cycle, all 2 * MAX_ELEMENTS nodes,
// with o_busy high. The receiver cannot stall the result.
module segment_tree_range_max_unit #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_BITS   = 32
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_op,
    input  logic [strmax_pkg::INDEX_BITS-1:0] i_element_index,
    input  logic [strmax_pkg::DATA_BITS-1:0]  i_element_value,
    input  logic [strmax_pkg::INDEX_BITS-1:0] i_range_low,
    input  logic [strmax_pkg::INDEX_BITS-1:0] i_range_high,
    input  logic                              i_cfg_we,
    input  logic [strmax_pkg::COUNT_BITS-1:0] i_cfg_wdata,
    output logic                              o_valid,
    output logic [strmax_pkg::DATA_BITS-1:0]  o_max_value
);
    import strmax_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    strmax_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_op     (i_op),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy)
    );

    strmax_datapath #(
        .MAX_ELEMENTS (MAX_ELEMENTS),
        .VALUE_BITS   (VALUE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_range_low     (i_range_low),
        .i_range_high    (i_range_high),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_valid         (o_valid),
        .o_max_value     (o_max_value)
    );

endmodule

@@ rtl/core/strmax_ctrl.sv @@
`timescale 1ns / 1ps
// Sequencer for the clearing pass, tree updates and range queries.
module strmax_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic                   i_op,
    input  strmax_pkg::t_dp_status i_status,
    output strmax_pkg::t_dp_cmd    o_cmd,
    output logic                   o_busy
);
    import strmax_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_start) begin
                    if (i_op == OP_QUERY) begin
                        n_state = i_status.q_empty ? S_IDLE : S_Q_RD;
                    end else begin
                        n_state = i_status.load_ok ? S_LEAF : S_IDLE;
                    end
                end
            end
            S_LEAF:   n_state = S_UPD_RD;
            S_UPD_RD: n_state = S_UPD_WR;
            S_UPD_WR: begin
                n_state = i_status.upd_last ? S_IDLE : S_UPD_RD;
            end
            S_Q_RD:   n_state = S_Q_ACC;
            S_Q_ACC: begin
                n_state = i_status.q_last ? S_IDLE : S_Q_RD;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            S_CLEAR: o_cmd.clr_step = 1'b1;
            S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.capture = 1'b1;
                    o_cmd.finish  = (i_op == OP_QUERY) && i_status.q_empty;
                end
            end
            S_LEAF:   o_cmd.leaf_wr = 1'b1;
            S_UPD_RD: o_cmd.rd_query = 1'b0;
            S_UPD_WR: o_cmd.upd_wr = 1'b1;
            S_Q_RD:   o_cmd.rd_query = 1'b1;
            S_Q_ACC: begin
                o_cmd.q_acc  = 1'b1;
                o_cmd.finish = i_status.q_last;
            end
            default:  o_busy = 1'b1;
        endcase
    end

endmodule

@@ rtl/core/strmax_datapath.sv @@
`timescale 1ns / 1ps
// Node memory, range pointers, accumulator and result register of the max tree.
module strmax_datapath #(
    parameter int MAX_ELEMENTS = 1024,
    parameter int VALUE_BITS   = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  strmax_pkg::t_dp_cmd                 i_cmd,
    output strmax_pkg::t_dp_status              o_status,
    input  logic [strmax_pkg::INDEX_BITS-1:0]   i_element_index,
    input  logic [strmax_pkg::DATA_BITS-1:0]    i_element_value,
    input  logic [strmax_pkg::INDEX_BITS-1:0]   i_range_low,
    input  logic [strmax_pkg::INDEX_BITS-1:0]   i_range_high,
    input  logic                                i_cfg_we,
    input  logic [strmax_pkg::COUNT_BITS-1:0]   i_cfg_wdata,
    output logic                                o_valid,
    output logic [strmax_pkg::DATA_BITS-1:0]    o_max_value
);
    import strmax_pkg::*;

    localparam int DEPTH  = 2 * MAX_ELEMENTS;
    localparam int NODE_W = $clog2(DEPTH);
    localparam int PTR_W  = NODE_W + 1;
    localparam int CMP_W  = (COUNT_BITS > PTR_W) ? COUNT_BITS : PTR_W;

    logic [VALUE_BITS-1:0] r_node_mem [DEPTH];
    logic [VALUE_BITS-1:0] r_rd_a;
    logic [VALUE_BITS-1:0] r_rd_b;

    logic [COUNT_BITS-1:0] r_count;
    logic [NODE_W-1:0]     r_clr;
    logic [NODE_W-1:0]     r_leaf;
    logic [NODE_W-1:0]     r_node;
    logic [VALUE_BITS-1:0] r_value;
    logic [PTR_W-1:0]      r_left;
    logic [PTR_W-1:0]      r_right;
    logic [VALUE_BITS-1:0] r_best;
    logic                  r_valid;
    logic [DATA_BITS-1:0]  r_out;

    logic [CMP_W-1:0]      cap;
    logic [CMP_W-1:0]      cnt;
    logic [CMP_W-1:0]      used;
    logic [CMP_W-1:0]      lo;
    logic [CMP_W-1:0]      hi;
    logic [CMP_W-1:0]      hi_clip;
    logic [CMP_W-1:0]      pos;
    logic [PTR_W-1:0]      right_m1;
    logic [PTR_W-1:0]      n_left;
    logic [PTR_W-1:0]      n_right;
    logic [VALUE_BITS-1:0] pick_a;
    logic [VALUE_BITS-1:0] pick_b;
    logic [VALUE_BITS-1:0] acc_ab;
    logic [VALUE_BITS-1:0] child_max;
    logic [VALUE_BITS-1:0] n_best;
    logic [NODE_W-1:0]     rd_addr_a;
    logic [NODE_W-1:0]     rd_addr_b;
    logic                  mem_we;
    logic [NODE_W-1:0]     mem_wa;
    logic [VALUE_BITS-1:0] mem_wd;

    always_comb begin
        cap     = CMP_W'(MAX_ELEMENTS);
        cnt     = CMP_W'(r_count);
        used    = (cnt > cap) ? cap : cnt;
        lo      = CMP_W'(i_range_low);
        hi      = CMP_W'(i_range_high);
        hi_clip = (hi > used - CMP_W'(1)) ? used - CMP_W'(1) : hi;
        pos     = CMP_W'(i_element_index);

        right_m1 = r_right - PTR_W'(1);
        n_left   = (r_left + PTR_W'(r_left[0])) >> 1;
        n_right  = (r_right - PTR_W'(r_right[0])) >> 1;

        o_status.clr_last = (r_clr == NODE_W'(DEPTH - 1));
        o_status.load_ok  = (pos < cap);
        o_status.q_empty  = (used == '0) || (lo > hi) || (lo >= used);
        o_status.upd_last = (r_node == NODE_W'(1));
        o_status.q_last   = (n_left >= n_right);

        pick_a    = r_left[0] ? r_rd_a : '0;
        pick_b    = r_right[0] ? r_rd_b : '0;
        acc_ab    = (pick_a > r_best) ? pick_a : r_best;
        child_max = (r_rd_a > r_rd_b) ? r_rd_a : r_rd_b;

        if (i_cmd.capture) begin
            n_best = '0;
        end else if (i_cmd.q_acc) begin
            n_best = (pick_b > acc_ab) ? pick_b : acc_ab;
        end else begin
            n_best = r_best;
        end

        if (i_cmd.rd_query) begin
            rd_addr_a = r_left[NODE_W-1:0];
            rd_addr_b = right_m1[NODE_W-1:0];
        end else begin
            rd_addr_a = {r_node[NODE_W-2:0], 1'b0};
            rd_addr_b = {r_node[NODE_W-2:0], 1'b1};
        end

        mem_we = i_cmd.clr_step | i_cmd.leaf_wr | i_cmd.upd_wr;
        if (i_cmd.clr_step) begin
            mem_wa = r_clr;
            mem_wd = '0;
        end else if (i_cmd.leaf_wr) begin
            mem_wa = r_leaf;
            mem_wd = r_value;
        end else begin
            mem_wa = r_node;
            mem_wd = child_max;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_node_mem[mem_wa] <= mem_wd;
        end
        r_rd_a <= r_node_mem[rd_addr_a];
        r_rd_b <= r_node_mem[rd_addr_b];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + NODE_W'(1);
            end
            r_valid <= i_cmd.finish;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best <= n_best;
        if (i_cmd.capture) begin
            r_leaf  <= NODE_W'(pos + cap);
            r_value <= VALUE_BITS'(i_element_value);
            r_left  <= PTR_W'(lo + cap);
            r_right <= PTR_W'(hi_clip + cap + CMP_W'(1));
        end else if (i_cmd.q_acc) begin
            r_left  <= n_left;
            r_right <= n_right;
        end
        if (i_cmd.leaf_wr) begin
            r_node <= r_leaf >> 1;
        end else if (i_cmd.upd_wr) begin
            r_node <= r_node >> 1;
        end
        if (i_cmd.finish) begin
            r_out <= DATA_BITS'(n_best);
        end
    end

    assign o_valid     = r_valid;
    assign o_max_value = r_out;

endmodule

@@ rtl/core/strmax_checker.sv @@
`timescale 1ns / 1ps
// Port-level checker for the segment tree range maximum unit, with its bind.
module strmax_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic i_op,
    input logic o_busy,
    input logic o_valid
);
    import strmax_pkg::*;

    a_reset_starts_clear: assert property (@(posedge i_clk) !i_rst_n |=> o_busy)
        else $error("Unit not busy after reset.");

    a_reset_kills_result: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("Result beat right after reset.");

    a_load_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_op == OP_LOAD)) |=> !o_valid)
        else $error("Load beat produced a result.");

    a_query_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && (i_op == OP_QUERY)) |=> (o_valid || o_busy))
        else $error("Query beat neither answered nor in progress.");

    a_result_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ($past(o_busy) || ($past(i_start) && ($past(i_op) == OP_QUERY))))
        else $error("Result beat without a query.");

endmodule

bind segment_tree_range_max_unit strmax_checker u_strmax_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_start (i_start),
    .i_op    (i_op),
    .o_busy  (o_busy),
    .o_valid (o_valid)
);

@@ tb/tb_segment_tree_range_max_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the segment tree range maximum unit, with a mirrored max tree.
module tb_segment_tree_range_max_unit;

    import strmax_pkg::*;

    localparam int CAPACITY      = 1024;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_BEATS  = 830;
    localparam int PEND_DEPTH    = 16;

    class max_tree_mirror;
        logic [DATA_BITS-1:0]  tree_node [0:2*CAPACITY-1];
        logic [COUNT_BITS-1:0] count;
        logic [DATA_BITS-1:0]  pending_max [0:PEND_DEPTH-1];
        int                    pend_head;
        int                    pend_tail;
        int                    mismatches;
        int                    loads_seen;
        int                    queries_seen;
        int                    results_seen;

        function new();
            foreach (tree_node[k]) tree_node[k] = '0;
            foreach (pending_max[k]) pending_max[k] = '0;
            count        = '0;
            pend_head    = 0;
            pend_tail    = 0;
            mismatches   = 0;
            loads_seen   = 0;
            queries_seen = 0;
            results_seen = 0;
        endfunction

        function int pending_count();
            return pend_tail - pend_head;
        endfunction

        function void load_leaf(logic [INDEX_BITS-1:0] idx, logic [DATA_BITS-1:0] value);
            int node;
            node = CAPACITY + idx;
            tree_node[node] = value;
            node = node >> 1;
            while (node >= 1) begin
                tree_node[node] = (tree_node[2*node] > tree_node[2*node+1]) ?
                                  tree_node[2*node] : tree_node[2*node+1];
                node = node >> 1;
            end
        endfunction

        function logic [DATA_BITS-1:0] range_max(logic [INDEX_BITS-1:0] lo,
                                                 logic [INDEX_BITS-1:0] hi);
            int                   used;
            int                   top;
            int                   left;
            int                   right;
            logic [DATA_BITS-1:0] best;
            used = (count > CAPACITY) ? CAPACITY : count;
            best = '0;
            if (used == 0 || lo > hi || lo >= used) return '0;
            top   = (hi > used - 1) ? used - 1 : hi;
            left  = lo + CAPACITY;
            right = top + CAPACITY + 1;
            while (left < right) begin
                if (left[0]) begin
                    if (tree_node[left] > best) best = tree_node[left];
                    left++;
                end
                if (right[0]) begin
                    right--;
                    if (tree_node[right] > best) best = tree_node[right];
                end
                left  = left >> 1;
                right = right >> 1;
            end
            return best;
        endfunction

        function void note_command(logic op, logic [INDEX_BITS-1:0] idx,
                                   logic [DATA_BITS-1:0] value,
                                   logic [INDEX_BITS-1:0] lo, logic [INDEX_BITS-1:0] hi);
            if (op == OP_LOAD) begin
                load_leaf(idx, value);
                loads_seen++;
            end else begin
                pending_max[pend_tail % PEND_DEPTH] = range_max(lo, hi);
                pend_tail++;
                queries_seen++;
            end
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("%0t ERROR: %s", $time, what);
        endtask

        task check_max(logic [DATA_BITS-1:0] got);
            logic [DATA_BITS-1:0] want;
            results_seen++;
            if (pending_count() == 0) begin
                report_mismatch($sformatf("unexpected result max_value=%h", got));
            end else begin
                want = pending_max[pend_head % PEND_DEPTH];
                pend_head++;
                if (got !== want)
                    report_mismatch($sformatf("max_value=%h, predicted %h", got, want));
            end
        endtask
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_start;
    logic                  o_busy;
    logic                  i_op;
    logic [INDEX_BITS-1:0] i_element_index;
    logic [DATA_BITS-1:0]  i_element_value;
    logic [INDEX_BITS-1:0] i_range_low;
    logic [INDEX_BITS-1:0] i_range_high;
    logic                  i_cfg_we;
    logic [COUNT_BITS-1:0] i_cfg_wdata;
    logic                  o_valid;
    logic [DATA_BITS-1:0]  o_max_value;

    max_tree_mirror mirror;
    int             cycle_count;
    int             config_writes;
    bit             idling_on;

    segment_tree_range_max_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_op            (i_op),
        .i_element_index (i_element_index),
        .i_element_value (i_element_value),
        .i_range_low     (i_range_low),
        .i_range_high    (i_range_high),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .o_valid         (o_valid),
        .o_max_value     (o_max_value)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && mirror != null) mirror.check_max(o_max_value);
    end

    task automatic send_beat(input logic op, input logic [INDEX_BITS-1:0] idx,
                             input logic [DATA_BITS-1:0] value,
                             input logic [INDEX_BITS-1:0] lo, input logic [INDEX_BITS-1:0] hi);
        int gap;
        if (idling_on && $urandom_range(99) < 8) begin
            gap = $urandom_range(6, 1);
            i_start = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_start         = 1'b1;
        i_op            = op;
        i_element_index = idx;
        i_element_value = value;
        i_range_low     = lo;
        i_range_high    = hi;
        do @(posedge i_clk); while (o_busy);
        mirror.note_command(op, idx, value, lo, hi);
        @(negedge i_clk);
    endtask

    task automatic send_load(input logic [INDEX_BITS-1:0] idx, input logic [DATA_BITS-1:0] value);
        send_beat(OP_LOAD, idx, value, INDEX_BITS'($urandom), INDEX_BITS'($urandom));
    endtask

    task automatic send_query(input logic [INDEX_BITS-1:0] lo, input logic [INDEX_BITS-1:0] hi);
        send_beat(OP_QUERY, INDEX_BITS'($urandom), $urandom, lo, hi);
    endtask

    task automatic write_count(input logic [COUNT_BITS-1:0] value);
        i_start = 1'b0;
        while (mirror.pending_count() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        while (o_busy) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = value;
        mirror.count = value;
        config_writes++;
        @(negedge i_clk);
        i_cfg_we    = 1'b0;
        i_cfg_wdata = COUNT_BITS'($urandom);
    endtask

    task automatic send_random_beat(input int used);
        int                    pick;
        int                    lo;
        int                    hi;
        logic [DATA_BITS-1:0]  value;
        logic [INDEX_BITS-1:0] idx;
        pick = $urandom_range(99);
        if (pick < 40) begin
            if (used > 0 && $urandom_range(9) < 8) idx = INDEX_BITS'($urandom_range(used - 1));
            else idx = INDEX_BITS'($urandom);
            pick = $urandom_range(99);
            if (pick < 10) value = '0;
            else if (pick < 20) value = '1;
            else if (pick < 50) value = $urandom_range(1000);
            else value = $urandom;
            send_load(idx, value);
        end else begin
            pick = $urandom_range(99);
            if (used > 0 && pick < 60) begin
                lo = $urandom_range(used - 1);
                hi = $urandom_range(used - 1, lo);
            end else if (used > 0 && pick < 75) begin
                lo = $urandom_range(used - 1);
                hi = lo + $urandom_range(8);
                if (hi > CAPACITY - 1) hi = CAPACITY - 1;
            end else begin
                lo = $urandom_range(CAPACITY - 1);
                hi = $urandom_range(CAPACITY - 1);
            end
            send_query(lo[INDEX_BITS-1:0], hi[INDEX_BITS-1:0]);
        end
    endtask

    initial begin
        int counts [9];
        int per_phase;
        int used;
        mirror          = new();
        cycle_count     = 0;
        config_writes   = 0;
        idling_on       = 1'b1;
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_op            = OP_LOAD;
        i_element_index = '0;
        i_element_value = '0;
        i_range_low     = '0;
        i_range_high    = '0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: count of zero, extreme values, clipping and empty ranges.
        send_query(10'd0, 10'd1023);
        write_count(11'd1024);
        send_query(10'd0, 10'd1023);
        send_load(10'd0, 32'hFFFF_FFFF);
        send_load(10'd1023, 32'h0000_0001);
        send_load(10'd512, 32'h8000_0000);
        send_load(10'd1, 32'h0000_0000);
        send_query(10'd0, 10'd1023);
        send_query(10'd1, 10'd1023);
        send_query(10'd1023, 10'd1023);
        send_query(10'd5, 10'd3);
        send_query(10'd513, 10'd1022);
        write_count(11'd2047);
        send_query(10'd0, 10'd1023);
        send_query(10'd1023, 10'd1023);
        write_count(11'd10);
        send_load(10'd7, 32'h1234_5678);
        send_query(10'd5, 10'd1023);
        send_query(10'd10, 10'd20);
        send_load(10'd700, 32'hDEAD_BEEF);
        send_query(10'd0, 10'd1023);
        write_count(11'd1024);
        send_query(10'd600, 10'd800);
        write_count(11'd0);
        send_query(10'd0, 10'd0);

        counts    = '{1024, 37, 2047, 1, 2, 600, 1023, 0, 0};
        counts[8] = $urandom_range(2047);
        per_phase = RANDOM_BEATS / 9;
        for (int p = 0; p < 9; p++) begin
            write_count(COUNT_BITS'(counts[p]));
            used      = (counts[p] > CAPACITY) ? CAPACITY : counts[p];
            idling_on = (p != 2);
            for (int n = 0; n < per_phase; n++) send_random_beat(used);
        end

        i_start = 1'b0;
        while (mirror.pending_count() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d loads and %0d queries over %0d element count settings.",
                 mirror.loads_seen, mirror.queries_seen, config_writes);
        $display("Checked %0d results, %0d mismatches.", mirror.results_seen, mirror.mismatches);
        if (mirror.mismatches == 0 && mirror.pending_count() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
